[design/ctt_pkg.sv]
`default_nettype none

package ctt_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int ID_BITS     = 16;
   localparam int COUNT_BITS  = 16;

   localparam int FIELD_W  = 16;
   localparam int KIND_W   = 3;
   localparam int ACTIVE_W = 5;
   localparam int ID_W     = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;
   localparam int REM_W    = (COUNT_BITS < FIELD_W) ? COUNT_BITS : FIELD_W;
   localparam int IDX_W    = $clog2(TIMER_SLOTS);
   localparam int USED_W   = $clog2(TIMER_SLOTS + 1);

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADDED     = 3'd0,
      KIND_FULL      = 3'd1,
      KIND_REMOVED   = 3'd2,
      KIND_NOT_FOUND = 3'd3,
      KIND_EXPIRED   = 3'd4,
      KIND_NONE      = 3'd5
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [REM_W-1:0] remaining;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [ID_W-1:0]   id;
      logic              last;
      logic [USED_W-1:0] active;
   } emit_type;

endpackage

`default_nettype wire

[design/ctt_store.sv]
`default_nettype none

module ctt_store (
   input  wire logic                 clock,
   input  wire ctt_pkg::mem_req_type mem_req,
   output ctt_pkg::entry_type        rd_data
);

   ctt_pkg::entry_type mem [ctt_pkg::TIMER_SLOTS];
   ctt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/ctt_ctrl.sv]
`default_nettype none

module ctt_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [1:0]                   req_command,
   input  wire logic [ctt_pkg::FIELD_W-1:0]  req_event_id,
   input  wire logic [ctt_pkg::FIELD_W-1:0]  req_tick_count,
   input  wire logic                         rsp_free,
   output ctt_pkg::emit_type                 emit,
   output ctt_pkg::mem_req_type              mem_req,
   input  wire ctt_pkg::entry_type           rd_data
);

   localparam int IDX_W  = ctt_pkg::IDX_W;
   localparam int USED_W = ctt_pkg::USED_W;
   localparam int ID_W   = ctt_pkg::ID_W;
   localparam int REM_W  = ctt_pkg::REM_W;

   ctt_pkg::state_type state_ff, state_in;
   ctt_pkg::cmd_type   cmd_ff, cmd_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [REM_W-1:0]   cnt_ff, cnt_in;
   logic [USED_W-1:0]  used_ff, used_in;
   logic [USED_W-1:0]  issue_ff, issue_in;
   logic [IDX_W-1:0]   rd_addr_ff, rd_addr_in;
   logic               p1_vld_ff, p1_vld_in;
   logic [IDX_W-1:0]   p1_idx_ff, p1_idx_in;
   logic               found_ff, found_in;
   logic [USED_W-1:0]  keep_ff, keep_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in;
   logic [USED_W-1:0]  pend_cnt_ff, pend_cnt_in;

   logic [REM_W-1:0]   rem_dec;
   logic               stall;
   logic               table_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ctt_pkg::ST_IDLE;
         used_ff     <= '0;
         issue_ff    <= '0;
         p1_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         issue_ff    <= issue_in;
         p1_vld_ff   <= p1_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      cnt_ff      <= cnt_in;
      rd_addr_ff  <= rd_addr_in;
      p1_idx_ff   <= p1_idx_in;
      found_ff    <= found_in;
      keep_ff     <= keep_in;
      pend_id_ff  <= pend_id_in;
      pend_cnt_ff <= pend_cnt_in;
   end

   assign table_full = (used_ff == USED_W'(ctt_pkg::TIMER_SLOTS));
   assign rem_dec    = (rd_data.remaining == '0) ? '0 : rd_data.remaining - REM_W'(1);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      id_in       = id_ff;
      cnt_in      = cnt_ff;
      used_in     = used_ff;
      issue_in    = issue_ff;
      rd_addr_in  = rd_addr_ff;
      p1_vld_in   = p1_vld_ff;
      p1_idx_in   = p1_idx_ff;
      found_in    = found_ff;
      keep_in     = keep_ff;
      pend_vld_in = pend_vld_ff;
      pend_id_in  = pend_id_ff;
      pend_cnt_in = pend_cnt_ff;
      req_ready   = 1'b0;
      stall       = 1'b0;
      emit        = '0;
      mem_req     = '0;

      unique case (state_ff)
         ctt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in      = ctt_pkg::cmd_type'(req_command);
               id_in       = req_event_id[ID_W-1:0];
               cnt_in      = (req_tick_count[REM_W-1:0] == '0) ? REM_W'(1)
                                                                : req_tick_count[REM_W-1:0];
               found_in    = 1'b0;
               keep_in     = '0;
               pend_vld_in = 1'b0;
               p1_vld_in   = 1'b0;
               if (ctt_pkg::cmd_type'(req_command) == ctt_pkg::CMD_ADD) begin
                  // shift walks from the oldest entry toward the front
                  issue_in   = table_full ? '0 : used_ff;
                  rd_addr_in = IDX_W'(used_ff - USED_W'(1));
               end else begin
                  issue_in   = used_ff;
                  rd_addr_in = '0;
               end
               if (ctt_pkg::cmd_type'(req_command) != ctt_pkg::CMD_NOP) begin
                  state_in = ctt_pkg::ST_SCAN;
               end
            end
         end

         ctt_pkg::ST_SCAN: begin
            // entry returned by the last read
            if (p1_vld_ff) begin
               case (cmd_ff)
                  ctt_pkg::CMD_ADD: begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = p1_idx_ff + IDX_W'(1);
                     mem_req.wr_data = rd_data;
                  end
                  ctt_pkg::CMD_REMOVE: begin
                     if (found_ff) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = p1_idx_ff - IDX_W'(1);
                        mem_req.wr_data = rd_data;
                     end else if (rd_data.id == id_ff) begin
                        found_in = 1'b1;
                     end
                  end
                  ctt_pkg::CMD_TICK: begin
                     if (rem_dec == '0) begin
                        // previous expiry leaves before this one takes the holding slot
                        if (pend_vld_ff) begin
                           if (rsp_free) begin
                              emit.valid  = 1'b1;
                              emit.kind   = ctt_pkg::KIND_EXPIRED;
                              emit.id     = pend_id_ff;
                              emit.last   = 1'b0;
                              emit.active = pend_cnt_ff;
                           end else begin
                              stall = 1'b1;
                           end
                        end
                        if (!stall) begin
                           pend_vld_in = 1'b1;
                           pend_id_in  = rd_data.id;
                           pend_cnt_in = used_ff - USED_W'(1);
                           used_in     = used_ff - USED_W'(1);
                        end
                     end else begin
                        mem_req.wr_en             = 1'b1;
                        mem_req.wr_addr           = keep_ff[IDX_W-1:0];
                        mem_req.wr_data.id        = rd_data.id;
                        mem_req.wr_data.remaining = rem_dec;
                        keep_in                   = keep_ff + USED_W'(1);
                     end
                  end
                  default: ;
               endcase
            end

            if (issue_ff != '0 && !stall) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_addr_ff;
               p1_vld_in       = 1'b1;
               p1_idx_in       = rd_addr_ff;
               rd_addr_in      = (cmd_ff == ctt_pkg::CMD_ADD) ? rd_addr_ff - IDX_W'(1)
                                                             : rd_addr_ff + IDX_W'(1);
               issue_in        = issue_ff - USED_W'(1);
            end else if (p1_vld_ff && !stall) begin
               p1_vld_in = 1'b0;
            end

            if (issue_ff == '0 && !p1_vld_ff && rsp_free) begin
               emit.valid  = 1'b1;
               emit.last   = 1'b1;
               emit.id     = id_ff;
               emit.active = used_ff;
               pend_vld_in = 1'b0;
               state_in    = ctt_pkg::ST_IDLE;
               case (cmd_ff)
                  ctt_pkg::CMD_ADD: begin
                     if (table_full) begin
                        emit.kind = ctt_pkg::KIND_FULL;
                     end else begin
                        mem_req.wr_en             = 1'b1;
                        mem_req.wr_addr           = '0;
                        mem_req.wr_data.id        = id_ff;
                        mem_req.wr_data.remaining = cnt_ff;
                        used_in                   = used_ff + USED_W'(1);
                        emit.kind                 = ctt_pkg::KIND_ADDED;
                        emit.active               = used_ff + USED_W'(1);
                     end
                  end
                  ctt_pkg::CMD_REMOVE: begin
                     if (found_ff) begin
                        used_in     = used_ff - USED_W'(1);
                        emit.kind   = ctt_pkg::KIND_REMOVED;
                        emit.active = used_ff - USED_W'(1);
                     end else begin
                        emit.kind = ctt_pkg::KIND_NOT_FOUND;
                     end
                  end
                  ctt_pkg::CMD_TICK: begin
                     if (pend_vld_ff) begin
                        emit.kind   = ctt_pkg::KIND_EXPIRED;
                        emit.id     = pend_id_ff;
                        emit.active = pend_cnt_ff;
                     end else begin
                        emit.kind = ctt_pkg::KIND_NONE;
                        emit.id   = '0;
                     end
                  end
                  default: begin
                     emit.valid = 1'b0;
                  end
               endcase
            end
         end

         default: begin
            state_in = ctt_pkg::ST_IDLE;
         end
      endcase
   end

   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("read and write hit the same slot");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> rsp_free)
      else $error("beat issued into a busy output register");

   a_used_in_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(ctt_pkg::TIMER_SLOTS))
      else $error("active count beyond table size");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ctt_pkg::ST_IDLE) |-> (!p1_vld_ff && !pend_vld_ff))
      else $error("work left in flight while idle");

   a_stall_holds_entry: assert property (@(posedge clock) disable iff (reset)
      stall |=> (p1_vld_ff && $stable(p1_idx_ff) && $stable(rd_data)))
      else $error("stalled entry lost");

endmodule

`default_nettype wire

[design/countdown_event_timer_table.sv]
// Add, remove and tick scan the occupied slots before the result beat; an empty table or a
//   refused add answers without a scan. Beats wait while the result side holds off.
// One command at a time: the next is taken once the last result of the previous one sits in
//   the output register. Each occupied slot is read once through the memory port per scan.
// Reset clears the active count and control state; slot memory needs no clearing pass.
`default_nettype none

module countdown_event_timer_table (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_command,
   input  wire logic [ctt_pkg::FIELD_W-1:0]    req_event_id,
   input  wire logic [ctt_pkg::FIELD_W-1:0]    req_tick_count,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [ctt_pkg::KIND_W-1:0]          rsp_kind,
   output logic [ctt_pkg::FIELD_W-1:0]         rsp_result_id,
   output logic                                rsp_last,
   output logic [ctt_pkg::ACTIVE_W-1:0]        rsp_active_count
);

   ctt_pkg::emit_type    emit;
   ctt_pkg::mem_req_type mem_req;
   ctt_pkg::entry_type   rd_data;
   logic                 rsp_free;

   logic                              rsp_valid_ff;
   ctt_pkg::kind_type                 rsp_kind_ff;
   logic [ctt_pkg::ID_W-1:0]          rsp_id_ff;
   logic                              rsp_last_ff;
   logic [ctt_pkg::USED_W-1:0]        rsp_active_ff;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   ctt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_event_id   (req_event_id),
      .req_tick_count (req_tick_count),
      .rsp_free       (rsp_free),
      .emit           (emit),
      .mem_req        (mem_req),
      .rd_data        (rd_data)
   );

   ctt_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit.valid) begin
         rsp_kind_ff   <= emit.kind;
         rsp_id_ff     <= emit.id;
         rsp_last_ff   <= emit.last;
         rsp_active_ff <= emit.active;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_result_id    = ctt_pkg::FIELD_W'(rsp_id_ff);
   assign rsp_last         = rsp_last_ff;
   assign rsp_active_count = ctt_pkg::ACTIVE_W'(rsp_active_ff);

   a_beat_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_id) && $stable(rsp_kind)))
      else $error("result beat changed while stalled");

endmodule

`default_nettype wire
